>>> rtl/assert_macros.svh
// Assertion macros shared by the calibrator RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Invariant that must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("invariant violated");

// Same-cycle implication.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> rtl/wmc_pkg.sv
// Shared constants, codes and types of the weighted mean calibrator.
// Depends on nothing; every other file of the block but assert_macros.svh imports it.
`timescale 1ns / 1ps

package wmc_pkg;

   // Field widths and fixed-point layout.
   localparam int LEN_W    = 24;
   localparam int CONF_W   = 17;
   localparam int COEFF_W  = 20;
   localparam int STATUS_W = 2;
   localparam int FRAC_W   = 16;
   localparam int VAR_W    = 32;
   localparam int PROD_W   = 48;
   localparam int ROOT_W   = 24;
   localparam int RAD_W    = 48;

   localparam logic [CONF_W-1:0]  CONF_ONE  = 17'd65536;
   localparam logic [COEFF_W-1:0] COEFF_MAX = 20'hFFFFF;

   // Default capacity of one run.
   localparam int WMC_MAX_SAMPLES = 1024;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

   // Configuration port layout.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAX_VARIATION = 1'b0;

   // Operating modes of the shared iteration unit.
   localparam logic MODE_DIV  = 1'b0;
   localparam logic MODE_SQRT = 1'b1;

   typedef struct packed {
      logic start;
      logic mode;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

>>> rtl/wmc_ifs.sv
// Valid/ready channel interfaces for sample transactions and result transactions.
// Depends on wmc_pkg for the field widths.
`timescale 1ns / 1ps

interface wmc_req_if;
   import wmc_pkg::*;

   logic                valid;
   logic                ready;
   logic [LEN_W-1:0]    sample_length;
   logic [CONF_W-1:0]   sample_confidence;
   logic                sample_valid;
   logic                last;

   modport source (
      output valid, sample_length, sample_confidence, sample_valid, last,
      input  ready
   );
   modport sink (
      input  valid, sample_length, sample_confidence, sample_valid, last,
      output ready
   );
endinterface

interface wmc_rsp_if;
   import wmc_pkg::*;

   logic                valid;
   logic                ready;
   logic [LEN_W-1:0]    avg_length;
   logic [CONF_W-1:0]   mean_confidence;
   logic [COEFF_W-1:0]  variation_coeff;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, avg_length, mean_confidence, variation_coeff, status,
      input  ready
   );
   modport sink (
      input  valid, avg_length, mean_confidence, variation_coeff, status,
      output ready
   );
endinterface

>>> rtl/wmc_csr.sv
// APB-style register file holding the variation limit.
// Depends on wmc_pkg for the address and data layout.
`timescale 1ns / 1ps

module wmc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wmc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wmc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wmc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [wmc_pkg::COEFF_W-1:0]    max_variation
);
   import wmc_pkg::*;

   logic [COEFF_W-1:0] max_var_ff;
   logic [COEFF_W-1:0] max_var_in;
   logic               reg_index;
   logic               wr_en;

   // Registers sit on 32-bit word boundaries.
   assign reg_index = paddr[2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Write decode.
   always_comb begin
      max_var_in = max_var_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_MAX_VARIATION: max_var_in = pwdata[COEFF_W-1:0];
            default: max_var_in = max_var_ff;
         endcase
      end
   end

   // Read decode; unmapped words read as zero.
   always_comb begin
      unique case (reg_index)
         REG_MAX_VARIATION: prdata = CSR_DATA_W'(max_var_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_var_ff <= '0;
      end else begin
         max_var_ff <= max_var_in;
      end
   end

   assign max_variation = max_var_ff;

endmodule

>>> rtl/wmc_iter_unit.sv
// Shared compare-and-subtract engine running restoring division or integer
// square root one step per cycle. Depends on wmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module wmc_iter_unit #(
   parameter int DVW = 59,
   parameter int DSW = 27
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wmc_pkg::unit_cmd_type  cmd,
   input  logic [DVW-1:0]         operand,
   input  logic [DSW-1:0]         divisor,
   output wmc_pkg::unit_stat_type stat,
   output logic [DVW-1:0]         result
);
   import wmc_pkg::*;
   `include "assert_macros.svh"

   // The remainder must hold a divide trial or a square-root trial.
   localparam int CW    = (DSW + 1 > ROOT_W + 2) ? DSW + 1 : ROOT_W + 2;
   localparam int CNT_W = $clog2(DVW + 1);

   logic [DVW-1:0]   acc_ff, acc_in;
   logic [DVW-1:0]   res_ff, res_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [DSW-1:0]   dsr_ff, dsr_in;
   logic             mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [CW-1:0] trial;
   logic [CW-1:0] subtrahend;
   logic [CW:0]   diff;
   logic          ge;

   // Trial operands: one dividend bit per step for division, two radicand
   // bits per step for the root.
   always_comb begin
      if (mode_ff == MODE_SQRT) begin
         trial      = {rem_ff[CW-3:0], acc_ff[DVW-1:DVW-2]};
         subtrahend = {res_ff[CW-3:0], 2'b01};
      end else begin
         trial      = {rem_ff[CW-2:0], acc_ff[DVW-1]};
         subtrahend = CW'(dsr_ff);
      end
   end

   // The one shared subtractor; its borrow is the compare result.
   assign diff = {1'b0, trial} - {1'b0, subtrahend};
   assign ge   = ~diff[CW];

   // Sequencing of the steps.
   always_comb begin
      acc_in  = acc_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         mode_in = cmd.mode;
         dsr_in  = divisor;
         rem_in  = '0;
         res_in  = '0;
         busy_in = 1'b1;
         if (cmd.mode == MODE_SQRT) begin
            acc_in = operand << (DVW - RAD_W);
            cnt_in = CNT_W'(ROOT_W);
         end else begin
            acc_in = operand;
            cnt_in = CNT_W'(DVW);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[CW-1:0] : trial;
         res_in = {res_ff[DVW-2:0], ge};
         acc_in = (mode_ff == MODE_SQRT) ? (acc_ff << 2) : (acc_ff << 1);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      mode_ff <= mode_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

   // A start always opens a busy window.
   `ASSERT_NEXT(a_start_busy, clock, reset, cmd.start, busy_ff)
   // Completion and busy never overlap.
   `ASSERT_IMPLY(a_done_idle, clock, reset, done_ff, !busy_ff)
   // A busy unit still has steps left.
   `ASSERT_IMPLY(a_busy_cnt, clock, reset, busy_ff, cnt_ff != '0)

endmodule

>>> rtl/weighted_mean_cov_calibrator.sv
// Weighted mean and coefficient of variation calibrator, top level.
// Depends on wmc_pkg, wmc_ifs, wmc_csr, wmc_iter_unit and assert_macros.svh.
//
// Flow: req_chan.ready is high only while the block waits for a sample. A
// sample that is invalid, or that finds the run already full, is not
// accumulated; a valid sample passes states S_SQ, S_T2, S_T1 and S_ACC, where
// the shared multiplier forms the square, the weighted square and the weighted
// length in turn. A sample flagged last then runs the closing sequence; unless
// the run overflowed or is empty, the shared iteration unit does three
// divisions and, for a nonzero mean, one coefficient division of DVW steps
// each and a square root of 24 steps, where DVW = 48 + clog2(MAX_SAMPLES + 1).
// The sequence ends with any wait for the output register to be free.
// A result waits in an output register, so the next run can start while the
// previous result has not yet been taken.
`timescale 1ns / 1ps

module weighted_mean_cov_calibrator #(
   parameter int MAX_SAMPLES = wmc_pkg::WMC_MAX_SAMPLES
) (
   input  logic                           clock,
   input  logic                           reset,
   wmc_req_if.sink                        req_chan,
   wmc_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wmc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wmc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wmc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import wmc_pkg::*;
   `include "assert_macros.svh"

   // Accumulator widths follow from the run capacity.
   localparam int CNTW = $clog2(MAX_SAMPLES + 1);
   localparam int S1W  = 40 + CNTW;
   localparam int SQW  = 48 + CNTW;
   localparam int WSW  = 16 + CNTW;
   localparam int DVW  = SQW;
   localparam int DSW  = (WSW > LEN_W) ? WSW : LEN_W;
   localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_SAMPLES);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SQ     = 4'd1;
   localparam logic [3:0] S_T2     = 4'd2;
   localparam logic [3:0] S_T1     = 4'd3;
   localparam logic [3:0] S_ACC    = 4'd4;
   localparam logic [3:0] S_CHECK  = 4'd5;
   localparam logic [3:0] S_MEAN_W = 4'd6;
   localparam logic [3:0] S_CONF_W = 4'd7;
   localparam logic [3:0] S_E2_W   = 4'd8;
   localparam logic [3:0] S_MSQ    = 4'd9;
   localparam logic [3:0] S_VAR    = 4'd10;
   localparam logic [3:0] S_SQRT_W = 4'd11;
   localparam logic [3:0] S_COEF_W = 4'd12;
   localparam logic [3:0] S_STATUS = 4'd13;
   localparam logic [3:0] S_OUT    = 4'd14;

   logic [3:0]          state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [CONF_W-1:0]   conf_ff, conf_in;
   logic                last_ff, last_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [S1W-1:0]      s1_ff, s1_in;
   logic [SQW-1:0]      s2_ff, s2_in;
   logic [WSW-1:0]      w_ff, w_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [LEN_W-1:0]    mean_ff, mean_in;
   logic [CONF_W-1:0]   mconf_ff, mconf_in;
   logic [VAR_W-1:0]    e2_ff, e2_in;
   logic [COEFF_W-1:0]  coeff_ff, coeff_in;
   logic [STATUS_W-1:0] code_ff, code_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]    rsp_mean_ff, rsp_mean_in;
   logic [CONF_W-1:0]   rsp_mconf_ff, rsp_mconf_in;
   logic [COEFF_W-1:0]  rsp_coeff_ff, rsp_coeff_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_load;

   logic [LEN_W-1:0]    mul_a;
   logic [VAR_W-1:0]    mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [VAR_W:0]      var_diff;
   logic [VAR_W-1:0]    var_c;
   logic [CONF_W-1:0]   conf_sat;
   logic [ROOT_W-1:0]   root;

   unit_cmd_type        unit_cmd;
   unit_stat_type       unit_stat;
   logic [DVW-1:0]      unit_operand;
   logic [DSW-1:0]      unit_divisor;
   logic [DVW-1:0]      unit_result;
   logic [COEFF_W-1:0]  max_variation;

   // Configuration registers.
   wmc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .max_variation (max_variation)
   );

   // Shared divide and square-root engine.
   wmc_iter_unit #(
      .DVW (DVW),
      .DSW (DSW)
   ) u_iter (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .operand (unit_operand),
      .divisor (unit_divisor),
      .stat    (unit_stat),
      .result  (unit_result)
   );

   // Confidence above one counts as one.
   assign conf_sat = (req_chan.sample_confidence > CONF_ONE) ?
                     CONF_ONE : req_chan.sample_confidence;

   // Shared multiplier; every product it forms stays below 2^48.
   always_comb begin
      unique case (state_ff)
         S_SQ: begin
            mul_a = len_ff;
            mul_b = VAR_W'(len_ff);
         end
         S_T2: begin
            mul_a = LEN_W'(conf_ff);
            mul_b = prod_ff[PROD_W-1:FRAC_W];
         end
         S_T1: begin
            mul_a = len_ff;
            mul_b = VAR_W'(conf_ff);
         end
         S_MSQ: begin
            mul_a = mean_ff;
            mul_b = VAR_W'(mean_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Variance as mean of squares less square of mean, clamped at zero.
   assign var_diff = {1'b0, e2_ff} - {1'b0, prod_ff[PROD_W-1:FRAC_W]};
   assign var_c    = var_diff[VAR_W] ? '0 : var_diff[VAR_W-1:0];
   assign root     = unit_result[ROOT_W-1:0];

   // Sequencer and datapath.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      conf_in      = conf_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      w_in         = w_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      mean_in      = mean_ff;
      mconf_in     = mconf_ff;
      e2_in        = e2_ff;
      coeff_in     = coeff_ff;
      code_in      = code_ff;
      unit_cmd     = '0;
      unit_operand = '0;
      unit_divisor = '0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               len_in  = req_chan.sample_length;
               conf_in = conf_sat;
               last_in = req_chan.last;
               if (req_chan.sample_valid && (cnt_ff < MAX_CNT)) begin
                  state_in = S_SQ;
               end else begin
                  // A valid sample that finds the run full marks overflow.
                  if (req_chan.sample_valid) begin
                     ovf_in = 1'b1;
                  end
                  state_in = req_chan.last ? S_CHECK : S_IDLE;
               end
            end
         end
         S_SQ: begin
            prod_in  = mul_p;
            state_in = S_T2;
         end
         S_T2: begin
            prod_in  = mul_p;
            state_in = S_T1;
         end
         S_T1: begin
            s2_in    = s2_ff + SQW'(prod_ff);
            prod_in  = mul_p;
            state_in = S_ACC;
         end
         S_ACC: begin
            s1_in    = s1_ff + S1W'(prod_ff);
            w_in     = w_ff + WSW'(conf_ff);
            cnt_in   = cnt_ff + CNTW'(1);
            state_in = last_ff ? S_CHECK : S_IDLE;
         end
         S_CHECK: begin
            mean_in  = '0;
            mconf_in = '0;
            coeff_in = '0;
            if (ovf_ff) begin
               code_in  = ST_OVERFLOW;
               state_in = S_OUT;
            end else if ((cnt_ff == '0) || (w_ff == '0)) begin
               code_in  = ST_EMPTY;
               state_in = S_OUT;
            end else begin
               // Weighted mean length.
               unit_cmd.start = 1'b1;
               unit_cmd.mode  = MODE_DIV;
               unit_operand   = DVW'(s1_ff);
               unit_divisor   = DSW'(w_ff);
               state_in       = S_MEAN_W;
            end
         end
         S_MEAN_W: begin
            if (unit_stat.done) begin
               mean_in = unit_result[LEN_W-1:0];
               // Mean confidence.
               unit_cmd.start = 1'b1;
               unit_cmd.mode  = MODE_DIV;
               unit_operand   = DVW'(w_ff);
               unit_divisor   = DSW'(cnt_ff);
               state_in       = S_CONF_W;
            end
         end
         S_CONF_W: begin
            if (unit_stat.done) begin
               mconf_in = unit_result[CONF_W-1:0];
               // Weighted mean of squares.
               unit_cmd.start = 1'b1;
               unit_cmd.mode  = MODE_DIV;
               unit_operand   = s2_ff;
               unit_divisor   = DSW'(w_ff);
               state_in       = S_E2_W;
            end
         end
         S_E2_W: begin
            if (unit_stat.done) begin
               e2_in    = unit_result[VAR_W-1:0];
               state_in = S_MSQ;
            end
         end
         S_MSQ: begin
            prod_in  = mul_p;
            state_in = S_VAR;
         end
         S_VAR: begin
            // Standard deviation in Q8.16 is the root of var scaled by 2^16.
            unit_cmd.start = 1'b1;
            unit_cmd.mode  = MODE_SQRT;
            unit_operand   = DVW'({var_c, {FRAC_W{1'b0}}});
            state_in       = S_SQRT_W;
         end
         S_SQRT_W: begin
            if (unit_stat.done) begin
               if (mean_ff == '0) begin
                  // Zero mean: no spread gives zero, any spread saturates.
                  coeff_in = (root != '0) ? COEFF_MAX : '0;
                  state_in = S_STATUS;
               end else begin
                  unit_cmd.start = 1'b1;
                  unit_cmd.mode  = MODE_DIV;
                  unit_operand   = DVW'({root, {FRAC_W{1'b0}}});
                  unit_divisor   = DSW'(mean_ff);
                  state_in       = S_COEF_W;
               end
            end
         end
         S_COEF_W: begin
            if (unit_stat.done) begin
               coeff_in = (|unit_result[DVW-1:COEFF_W]) ?
                          COEFF_MAX : unit_result[COEFF_W-1:0];
               state_in = S_STATUS;
            end
         end
         S_STATUS: begin
            code_in  = ((max_variation != '0) && (coeff_ff > max_variation)) ?
                       ST_REJECTED : ST_OK;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hand over once the output register is free, then clear the run.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               s1_in    = '0;
               s2_in    = '0;
               w_in     = '0;
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_mconf_in  = rsp_mconf_ff;
      rsp_coeff_in  = rsp_coeff_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_mean_in   = mean_ff;
         rsp_mconf_in  = mconf_ff;
         rsp_coeff_in  = coeff_ff;
         rsp_status_in = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         s1_ff        <= '0;
         s2_ff        <= '0;
         w_ff         <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         w_ff         <= w_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      conf_ff       <= conf_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      mean_ff       <= mean_in;
      mconf_ff      <= mconf_in;
      e2_ff         <= e2_in;
      coeff_ff      <= coeff_in;
      code_ff       <= code_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_mconf_ff  <= rsp_mconf_in;
      rsp_coeff_ff  <= rsp_coeff_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.avg_length      = rsp_mean_ff;
   assign rsp_chan.mean_confidence = rsp_mconf_ff;
   assign rsp_chan.variation_coeff = rsp_coeff_ff;
   assign rsp_chan.status          = rsp_status_ff;

   // The run never holds more samples than its capacity.
   `ASSERT_PROP(a_cnt_bound, clock, reset, cnt_ff <= MAX_CNT)
   // The shared unit is only started when it is free.
   `ASSERT_IMPLY(a_start_free, clock, reset, unit_cmd.start, !unit_stat.busy)
   // The coefficient division never sees a zero mean.
   `ASSERT_IMPLY(a_coef_divisor, clock, reset,
                 unit_cmd.start && (state_ff == S_SQRT_W), mean_ff != '0)
   // A run that overflowed always reports overflow.
   `ASSERT_IMPLY(a_ovf_status, clock, reset, rsp_load && ovf_ff,
                 rsp_status_in == ST_OVERFLOW)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the weighted mean and coefficient of variation calibrator.
// Depends on wmc_pkg, the wmc_ifs channel interfaces and the calibrator top level.
`timescale 1ns / 1ps

module tb_top;
   import wmc_pkg::*;

   localparam int RUN_CAP = WMC_MAX_SAMPLES;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_MAX_VARIATION);

   typedef struct packed {
      logic [LEN_W-1:0]    avg_length;
      logic [CONF_W-1:0]   mean_confidence;
      logic [COEFF_W-1:0]  variation_coeff;
      logic [STATUS_W-1:0] status;
   } stats_type;

   // Tracks the running sums of the open run and predicts the statistics of each closed run.
   class calib_scoreboard;
      logic [COEFF_W-1:0] limit;
      longint unsigned len_sum, sq_sum, wt_sum;
      int unsigned count;
      bit overflowed;
      stats_type pending_stats[$];
      int errors;

      function new();
         limit = '0;
         errors = 0;
         clear_run();
      endfunction

      function void clear_run();
         len_sum = 0;
         sq_sum = 0;
         wt_sum = 0;
         count = 0;
         overflowed = 0;
      endfunction

      task report(input string msg);
         $display("ERROR at %0t ns: %s", $time, msg);
         errors++;
      endtask

      // Largest r with r*r <= v, built one bit at a time.
      function longint unsigned int_root(longint unsigned v);
         longint unsigned r, t;
         r = 0;
         for (int b = 23; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function int outstanding();
         return pending_stats.size();
      endfunction

      // Called for every accepted sample transaction.
      function void note_sample(input logic [LEN_W-1:0] length, input logic [CONF_W-1:0] conf,
                                input logic keep, input logic close);
         longint unsigned len, wt, lin, sq, mean, mconf, e2, m2, spread, dev, coeff;
         stats_type want;
         len = length;
         wt = (conf > CONF_ONE) ? CONF_ONE : conf;
         want = '0;
         if (keep) begin
            lin = wt * len;
            sq = wt * ((len * len) >> 16);
            if (count >= RUN_CAP || len_sum > ~lin || sq_sum > ~sq || wt_sum > ~wt) begin
               overflowed = 1;
            end else begin
               len_sum += lin;
               sq_sum += sq;
               wt_sum += wt;
               count++;
            end
         end
         if (!close) return;

         if (overflowed) begin
            want.status = ST_OVERFLOW;
         end else if (count == 0 || wt_sum == 0) begin
            want.status = ST_EMPTY;
         end else begin
            mean = len_sum / wt_sum;
            mconf = wt_sum / count;
            e2 = sq_sum / wt_sum;
            m2 = (mean * mean) >> 16;
            spread = (e2 > m2) ? e2 - m2 : 0;
            if (spread > 64'hFFFF_FFFF) spread = 64'hFFFF_FFFF;
            dev = int_root(spread << 16);
            // A zero mean gives either no variation or the saturated coefficient.
            if (mean == 0) begin
               coeff = (dev == 0) ? 0 : COEFF_MAX;
            end else begin
               coeff = (dev << 16) / mean;
               if (coeff > COEFF_MAX) coeff = COEFF_MAX;
            end
            want.avg_length = mean[LEN_W-1:0];
            want.mean_confidence = mconf[CONF_W-1:0];
            want.variation_coeff = coeff[COEFF_W-1:0];
            want.status = (limit != 0 && coeff > limit) ? ST_REJECTED : ST_OK;
         end
         pending_stats = {pending_stats, want};
         clear_run();
      endfunction

      // Called for every accepted result transaction.
      task check_stats(input stats_type got);
         stats_type want;
         if (pending_stats.size() == 0) begin
            report($sformatf("unexpected result mean %0h conf %0h coeff %0h status %0d",
                             got.avg_length, got.mean_confidence, got.variation_coeff,
                             got.status));
            return;
         end
         want = pending_stats.pop_front();
         if (got.avg_length !== want.avg_length)
            report($sformatf("mean length %0h, expected %0h",
                             got.avg_length, want.avg_length));
         if (got.mean_confidence !== want.mean_confidence)
            report($sformatf("mean_confidence %0h, expected %0h",
                             got.mean_confidence, want.mean_confidence));
         if (got.variation_coeff !== want.variation_coeff)
            report($sformatf("variation_coeff %0h, expected %0h",
                             got.variation_coeff, want.variation_coeff));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
      endtask

      task flush();
         while (pending_stats.size() != 0) begin
            void'(pending_stats.pop_front());
            report("expected result never arrived");
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   wmc_req_if req_chan();
   wmc_rsp_if rsp_chan();

   calib_scoreboard sb;
   bit steady;
   int samples_sent;

   weighted_mean_cov_calibrator #(
      .MAX_SAMPLES(RUN_CAP)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run time limit.
   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

   // Result side: random back-pressure, none while the steady window is open.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = steady || ($urandom_range(99) >= 36);
      end
   end

   // Every result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_stats({rsp_chan.avg_length, rsp_chan.mean_confidence,
                         rsp_chan.variation_coeff, rsp_chan.status});
   end

   // Sends one sample transaction; entered and left at a falling edge.
   task push_sample(input logic [LEN_W-1:0] len, input logic [CONF_W-1:0] conf,
                    input logic keep, input logic close);
      while (!steady && $urandom_range(99) < 36) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.sample_length = len;
      req_chan.sample_confidence = conf;
      req_chan.sample_valid = keep;
      req_chan.last = close;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_sample(len, conf, keep, close);
      samples_sent++;
      @(negedge clock);
   endtask

   // Waits until every predicted result has come and the block has gone quiet.
   task settle();
      req_chan.valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes the variation limit, then reads it back.
   task program_limit(input logic [COEFF_W-1:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = LIMIT_ADDR;
      pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.limit = value;
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(value))
         sb.report($sformatf("max_variation reads %0h, written %0h", prdata, value));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // One run with random size, length profile, weights and dropped samples.
   task random_run();
      int n, style, drop_pct, mask, pick;
      logic [LEN_W-1:0] base, len;
      logic [CONF_W-1:0] wt;
      n = ($urandom_range(4) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
      style = $urandom_range(3);
      drop_pct = ($urandom_range(9) == 0) ? 100 : (($urandom_range(3) == 0) ? 50 : 8);
      base = LEN_W'($urandom);
      mask = (1 << $urandom_range(20)) - 1;
      for (int i = 0; i < n; i++) begin
         case (style)
            0: len = LEN_W'($urandom);
            1: len = base + LEN_W'($urandom & mask);
            2: len = LEN_W'($urandom_range(1023));
            default: len = base;
         endcase
         pick = $urandom_range(15);
         if (pick == 0) wt = '0;
         else if (pick == 1) wt = CONF_ONE;
         else if (pick == 2) wt = CONF_W'($urandom_range(131071, 65537));
         else wt = CONF_W'($urandom_range(65536));
         push_sample(len, wt, $urandom_range(99) >= drop_pct, i == n - 1);
      end
   endtask

   // Main sequence.
   initial begin
      logic [COEFF_W-1:0] phase_limit [6];
      int budget, wait_cycles;

      sb = new();
      steady = 1'b0;
      samples_sent = 0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.sample_length = '0;
      req_chan.sample_confidence = '0;
      req_chan.sample_valid = 1'b0;
      req_chan.last = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed runs with the limit at its reset value.
      push_sample('0, '0, 1'b0, 1'b1);                 // nothing held
      push_sample(24'hFFFFFF, CONF_ONE, 1'b1, 1'b1);   // largest length, full weight
      push_sample(24'h001234, '0, 1'b1, 1'b1);         // zero weight sum
      push_sample(24'h123456, 17'h1FFFF, 1'b1, 1'b0);  // weights above one saturate
      push_sample(24'h654321, 17'd65537, 1'b1, 1'b0);
      push_sample(24'h000100, 17'd1, 1'b1, 1'b1);
      push_sample('0, CONF_ONE, 1'b1, 1'b0);           // zero mean, no spread
      push_sample('0, CONF_ONE, 1'b1, 1'b1);
      push_sample('0, CONF_ONE, 1'b1, 1'b0);           // widest spread
      push_sample(24'hFFFFFF, CONF_ONE, 1'b1, 1'b1);
      push_sample(24'h010000, CONF_ONE, 1'b1, 1'b0);   // invalid samples in the middle and last
      push_sample(24'hABCDEF, 17'd1000, 1'b0, 1'b0);
      push_sample(24'h020000, 17'd32768, 1'b1, 1'b0);
      push_sample(24'hFFFFFF, CONF_ONE, 1'b0, 1'b1);
      push_sample(24'h000001, 17'd1, 1'b1, 1'b1);      // smallest nonzero sample

      // Tightest nonzero limit: any spread is rejected, a flat run passes.
      settle();
      program_limit(20'd1);
      push_sample(24'h010000, CONF_ONE, 1'b1, 1'b0);
      push_sample(24'h030000, CONF_ONE, 1'b1, 1'b1);
      push_sample(24'h050000, 17'd40000, 1'b1, 1'b0);
      push_sample(24'h050000, 17'd12345, 1'b1, 1'b1);

      // A run filled exactly to capacity whose closing sample no longer fits;
      // neither side idles during it.
      steady = 1'b1;
      for (int i = 0; i < RUN_CAP; i++)
         push_sample(LEN_W'($urandom), CONF_W'($urandom_range(131071)), 1'b1, 1'b0);
      push_sample(LEN_W'($urandom), CONF_W'($urandom_range(65536)), 1'b1, 1'b1);
      steady = 1'b0;

      // Mean truncates to zero while the spread does not: coefficient saturates,
      // which the largest limit still accepts.
      settle();
      program_limit(COEFF_MAX);
      for (int i = 0; i < 256; i++)
         push_sample('0, CONF_ONE, 1'b1, 1'b0);
      push_sample(24'hFFFFFF, 17'd1, 1'b1, 1'b1);

      // Random runs under a series of limits; the third phase runs without idling.
      phase_limit = '{COEFF_MAX, 20'd0, 20'd30000, 20'd1, 20'd45000,
                      COEFF_W'($urandom_range(1048575, 1))};
      for (int p = 0; p < 6; p++) begin
         settle();
         program_limit(phase_limit[p]);
         steady = (p == 2);
         budget = samples_sent + 35;
         while (samples_sent < budget) random_run();
      end

      // Drain, then give the block time to show any stray result.
      req_chan.valid = 1'b0;
      for (wait_cycles = 0; sb.outstanding() != 0 && wait_cycles < 20000; wait_cycles++)
         @(posedge clock);
      repeat (300) @(posedge clock);
      sb.flush();
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
